// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/ore_pkg.sv =====
// ----------------------------------------------------------------------------
// ore_pkg
// Shared types and constants for the overwriting event record ring.
// ----------------------------------------------------------------------------
package ore_pkg;

    // Command codes
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TAKE  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Controller states
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_STREAM = 1'b1
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic wr;          // store record at head
        logic clr;         // empty ring, zero counter
        logic take_load;   // load read pointer and take length
        logic take_empty;  // emit the invalid result of an empty take
        logic rd_step;     // read one record and emit it
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic take_zero;   // take would return nothing
        logic rd_last;     // current read is the final one of the take
    } stat_t;

    // Record layout in the ring memory
    localparam int STAMP_W = 32;
    localparam int ARG_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int REC_W   = STAMP_W + ARG_W + 3 * BYTE_W;
    localparam int SEV_LSB   = 0;
    localparam int TAG_LSB   = SEV_LSB + BYTE_W;
    localparam int CODE_LSB  = TAG_LSB + BYTE_W;
    localparam int ARG_LSB   = CODE_LSB + BYTE_W;
    localparam int STAMP_LSB = ARG_LSB + ARG_W;
    localparam int DROP_W    = 16;
    localparam int LIMIT_W   = 8;

endpackage

// ===== src/ore_ctrl.sv =====
// ----------------------------------------------------------------------------
// ore_ctrl
// Command controller: decodes accepted commands and sequences take streams.
// ----------------------------------------------------------------------------
module ore_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          command,
    input  ore_pkg::stat_t      stat,
    output logic                busy,
    output ore_pkg::ctl_t       ctl
);

    ore_pkg::state_t state_reg;
    ore_pkg::state_t state_next;
    logic            take_req;

    assign take_req = start && (command == ore_pkg::CMD_TAKE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ore_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ore_pkg::ST_IDLE:
            begin
                if (take_req && !stat.take_zero)
                begin
                    state_next = ore_pkg::ST_STREAM;
                end
            end
            ore_pkg::ST_STREAM:
            begin
                if (stat.rd_last)
                begin
                    state_next = ore_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ore_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl  = '0;
        busy = 1'b0;
        unique case (state_reg)
            ore_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (ore_pkg::cmd_t'(command))
                        ore_pkg::CMD_WRITE: ctl.wr  = 1'b1;
                        ore_pkg::CMD_CLEAR: ctl.clr = 1'b1;
                        ore_pkg::CMD_TAKE:
                        begin
                            ctl.take_empty = stat.take_zero;
                            ctl.take_load  = !stat.take_zero;
                        end
                        default: ;
                    endcase
                end
            end
            ore_pkg::ST_STREAM:
            begin
                busy        = 1'b1;
                ctl.rd_step = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== src/ore_datapath.sv =====
// ----------------------------------------------------------------------------
// ore_datapath
// Ring memory, head pointer, pending and dropped counters, read sequencing
// and the registered result beat.
// ----------------------------------------------------------------------------
module ore_datapath #(
    parameter int RING_DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ore_pkg::ctl_t                         ctl,
    output ore_pkg::stat_t                        stat,
    input  logic [31:0]                           stamp_ms,
    input  logic [7:0]                            severity,
    input  logic [7:0]                            source_tag,
    input  logic [7:0]                            event_code,
    input  logic signed [31:0]                    event_arg,
    input  logic [7:0]                            take_limit,
    output logic                                  strobe,
    output logic                                  rec_valid,
    output logic [31:0]                           rec_stamp_ms,
    output logic [7:0]                            rec_severity,
    output logic [7:0]                            rec_tag,
    output logic [7:0]                            rec_code,
    output logic signed [31:0]                    rec_arg,
    output logic                                  last,
    output logic [$clog2(RING_DEPTH + 1) - 1:0]   pending_count,
    output logic [15:0]                           dropped_total
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = (CNT_W > ore_pkg::LIMIT_W) ? CNT_W : ore_pkg::LIMIT_W;
    localparam int SUM_W = CNT_W + 1;

    logic [ore_pkg::REC_W-1:0]  mem [RING_DEPTH];
    logic [ore_pkg::REC_W-1:0]  rd_data_reg;

    logic [PTR_W-1:0]           wp_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [CNT_W-1:0]           pending_reg;
    logic [CNT_W-1:0]           remain_reg;
    logic [ore_pkg::DROP_W-1:0] dropped_reg;

    logic                       strobe_reg;
    logic                       valid_reg;
    logic                       last_reg;
    logic [CNT_W-1:0]           pcnt_reg;
    logic [ore_pkg::DROP_W-1:0] drop_out_reg;

    logic [PTR_W-1:0]           wp_inc;
    logic [PTR_W-1:0]           rd_inc;
    logic [PTR_W-1:0]           oldest;
    logic [SUM_W-1:0]           wp_ext;
    logic [SUM_W-1:0]           pend_ext;
    logic [CNT_W-1:0]           taken;
    logic                       full;

    // Pointer wrap, oldest slot and take length
    always_comb
    begin
        wp_inc   = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        rd_inc   = (rd_ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        full     = (pending_reg == CNT_W'(RING_DEPTH));
        wp_ext   = SUM_W'(wp_reg);
        pend_ext = SUM_W'(pending_reg);
        if (wp_ext >= pend_ext)
        begin
            oldest = PTR_W'(wp_ext - pend_ext);
        end
        else
        begin
            oldest = PTR_W'(wp_ext + SUM_W'(RING_DEPTH) - pend_ext);
        end
        if (CMP_W'(take_limit) < CMP_W'(pending_reg))
        begin
            taken = CNT_W'(take_limit);
        end
        else
        begin
            taken = pending_reg;
        end
        stat.take_zero = (pending_reg == '0) || (take_limit == '0);
        stat.rd_last   = (remain_reg == CNT_W'(1));
    end

    // Ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            pending_reg <= '0;
            dropped_reg <= '0;
            rd_ptr_reg  <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            priority if (ctl.clr)
            begin
                wp_reg      <= '0;
                pending_reg <= '0;
                dropped_reg <= '0;
            end
            else if (ctl.wr)
            begin
                wp_reg <= wp_inc;
                if (full)
                begin
                    dropped_reg <= dropped_reg + 1'b1;
                end
                else
                begin
                    pending_reg <= pending_reg + 1'b1;
                end
            end
            else if (ctl.take_load)
            begin
                rd_ptr_reg <= oldest;
                remain_reg <= taken;
            end
            else if (ctl.rd_step)
            begin
                rd_ptr_reg  <= rd_inc;
                remain_reg  <= remain_reg - 1'b1;
                pending_reg <= pending_reg - 1'b1;
            end
        end
    end

    // Result beat registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg   <= 1'b0;
            valid_reg    <= 1'b0;
            last_reg     <= 1'b0;
            pcnt_reg     <= '0;
            drop_out_reg <= '0;
        end
        else
        begin
            strobe_reg   <= ctl.take_empty | ctl.rd_step;
            valid_reg    <= ctl.rd_step;
            last_reg     <= ctl.take_empty | (ctl.rd_step & stat.rd_last);
            pcnt_reg     <= ctl.rd_step ? pending_reg - 1'b1 : pending_reg;
            drop_out_reg <= dropped_reg;
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wp_reg] <= {stamp_ms, event_arg, event_code, source_tag, severity};
        end
        if (ctl.rd_step)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // Record fields read as zero on the invalid beat of an empty take
    assign strobe        = strobe_reg;
    assign rec_valid     = valid_reg;
    assign last          = last_reg;
    assign pending_count = pcnt_reg;
    assign dropped_total = drop_out_reg;
    assign rec_stamp_ms  = valid_reg ?
        rd_data_reg[ore_pkg::STAMP_LSB +: ore_pkg::STAMP_W] : '0;
    assign rec_arg       = valid_reg ?
        $signed(rd_data_reg[ore_pkg::ARG_LSB +: ore_pkg::ARG_W]) : '0;
    assign rec_code      = valid_reg ?
        rd_data_reg[ore_pkg::CODE_LSB +: ore_pkg::BYTE_W] : '0;
    assign rec_tag       = valid_reg ?
        rd_data_reg[ore_pkg::TAG_LSB +: ore_pkg::BYTE_W] : '0;
    assign rec_severity  = valid_reg ?
        rd_data_reg[ore_pkg::SEV_LSB +: ore_pkg::BYTE_W] : '0;

endmodule

// ===== src/overwriting_event_record_ring.sv =====
// Write and clear: no result beat; accepted back to back.
// Take: first beat after the read pointer load and the registered first read,
// then one record beat per cycle (one read per cycle on the single memory read
// port); busy while the records stream. Empty take: one invalid beat in the
// cycle after accept, never busy. Reset (async, active low) empties the ring and
// zeroes pending and dropped. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// overwriting_event_record_ring
// Ring of event records that overwrites the oldest entry when full and
// streams the oldest pending records on a take command.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module overwriting_event_record_ring #(
    parameter int RING_DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            command,
    input  logic [31:0]                           stamp_ms,
    input  logic [7:0]                            severity,
    input  logic [7:0]                            source_tag,
    input  logic [7:0]                            event_code,
    input  logic signed [31:0]                    event_arg,
    input  logic [7:0]                            take_limit,
    output logic                                  strobe,
    output logic                                  rec_valid,
    output logic [31:0]                           rec_stamp_ms,
    output logic [7:0]                            rec_severity,
    output logic [7:0]                            rec_tag,
    output logic [7:0]                            rec_code,
    output logic signed [31:0]                    rec_arg,
    output logic                                  last,
    output logic [$clog2(RING_DEPTH + 1) - 1:0]   pending_count,
    output logic [15:0]                           dropped_total
);

    ore_pkg::ctl_t  ctl;
    ore_pkg::stat_t stat;
    logic           take_acc;

    assign take_acc = start && !busy && (command == ore_pkg::CMD_TAKE);

    ore_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .busy    (busy),
        .ctl     (ctl)
    );

    ore_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .stamp_ms      (stamp_ms),
        .severity      (severity),
        .source_tag    (source_tag),
        .event_code    (event_code),
        .event_arg     (event_arg),
        .take_limit    (take_limit),
        .strobe        (strobe),
        .rec_valid     (rec_valid),
        .rec_stamp_ms  (rec_stamp_ms),
        .rec_severity  (rec_severity),
        .rec_tag       (rec_tag),
        .rec_code      (rec_code),
        .rec_arg       (rec_arg),
        .last          (last),
        .pending_count (pending_count),
        .dropped_total (dropped_total)
    );

    // An invalid beat is always the single, final beat of an empty take
    `ASSERT_IMPLY(a_empty_last, clk, rst_n, strobe && !rec_valid, last && $past(take_acc))
    // Every record read produces a valid beat in the next cycle
    `ASSERT_NEXT(a_read_beat, clk, rst_n, ctl.rd_step, strobe && rec_valid)
    // Pending count never exceeds the ring depth
    `ASSERT_IMPLY(a_pend_max, clk, rst_n, strobe, pending_count <= RING_DEPTH)
    // Streaming ends exactly after the final read
    `ASSERT_NEXT(a_stream_end, clk, rst_n, busy && stat.rd_last, !busy && last)

endmodule

// ===== bench/tb_overwriting_event_record_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overwriting_event_record_ring
// Self-checking bench for the overwriting event record ring. Commands are
// driven through the start/busy handshake. A behavioral copy of the ring
// predicts every take beat, and a monitor compares each strobed beat with
// the oldest prediction. Covers empty takes, field extremes, unused
// commands, clear, overflow with dropped-counter counting, and mixed random
// traffic with sender idle bursts.
// ----------------------------------------------------------------------------
module tb_overwriting_event_record_ring;

    localparam int         RING_SLOTS  = 32;
    localparam int         PEND_W      = $clog2(RING_SLOTS + 1);
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         REPORT_MAX  = 10;

    // One command beat as driven on the input ports
    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        stamp_ms;
        logic [7:0]         severity;
        logic [7:0]         source_tag;
        logic [7:0]         event_code;
        logic signed [31:0] event_arg;
        logic [7:0]         take_limit;
    } cmd_beat_t;

    // One stored event record
    typedef struct packed {
        logic [31:0]        stamp;
        logic [7:0]         sev;
        logic [7:0]         tag;
        logic [7:0]         code;
        logic signed [31:0] arg;
    } event_rec_t;

    // One result beat of a take
    typedef struct packed {
        logic              valid;
        event_rec_t        rec;
        logic              last;
        logic [PEND_W-1:0] pending;
        logic [15:0]       dropped;
    } take_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] command = 2'd0;
    logic [31:0] stamp_ms = 32'd0;
    logic [7:0] severity = 8'd0;
    logic [7:0] source_tag = 8'd0;
    logic [7:0] event_code = 8'd0;
    logic signed [31:0] event_arg = 32'sd0;
    logic [7:0] take_limit = 8'd0;

    logic busy;
    logic strobe;
    logic rec_valid;
    logic [31:0] rec_stamp_ms;
    logic [7:0] rec_severity;
    logic [7:0] rec_tag;
    logic [7:0] rec_code;
    logic signed [31:0] rec_arg;
    logic last;
    logic [PEND_W-1:0] pending_count;
    logic [15:0] dropped_total;

    // Predicted ring contents and counters
    event_rec_t ring_mem [RING_SLOTS];
    int         head_slot;
    int         pending_recs;
    logic [15:0] dropped_recs;

    take_beat_t take_beats_due[$];
    int         mismatch_count;
    int         cycle_count;
    bit         idling_on;

    overwriting_event_record_ring #(
        .RING_DEPTH(RING_SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .stamp_ms      (stamp_ms),
        .severity      (severity),
        .source_tag    (source_tag),
        .event_code    (event_code),
        .event_arg     (event_arg),
        .take_limit    (take_limit),
        .strobe        (strobe),
        .rec_valid     (rec_valid),
        .rec_stamp_ms  (rec_stamp_ms),
        .rec_severity  (rec_severity),
        .rec_tag       (rec_tag),
        .rec_code      (rec_code),
        .rec_arg       (rec_arg),
        .last          (last),
        .pending_count (pending_count),
        .dropped_total (dropped_total)
    );

    always #4 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Apply one accepted command to the ring copy and queue its take beats
    function automatic void apply_ring_command(input cmd_beat_t beat);
        int         taken;
        int         slot;
        take_beat_t due;
        due = '0;
        case (beat.command)
            ore_pkg::CMD_WRITE:
            begin
                ring_mem[head_slot] = '{beat.stamp_ms, beat.severity, beat.source_tag,
                                        beat.event_code, beat.event_arg};
                head_slot = (head_slot + 1) % RING_SLOTS;
                if (pending_recs < RING_SLOTS)
                    pending_recs++;
                else
                    dropped_recs = dropped_recs + 16'd1;
            end
            ore_pkg::CMD_CLEAR:
            begin
                head_slot    = 0;
                pending_recs = 0;
                dropped_recs = '0;
            end
            ore_pkg::CMD_TAKE:
            begin
                taken = (pending_recs < beat.take_limit) ? pending_recs : beat.take_limit;
                if (taken == 0)
                begin
                    // nothing to give: one invalid beat carrying the counters
                    due.last    = 1'b1;
                    due.pending = PEND_W'(pending_recs);
                    due.dropped = dropped_recs;
                    take_beats_due.push_back(due);
                end
                else
                begin
                    slot = (head_slot + RING_SLOTS - pending_recs) % RING_SLOTS;
                    for (int i = 0; i < taken; i++)
                    begin
                        pending_recs--;
                        due.valid   = 1'b1;
                        due.rec     = ring_mem[slot];
                        due.last    = (i + 1 == taken);
                        due.pending = PEND_W'(pending_recs);
                        due.dropped = dropped_recs;
                        take_beats_due.push_back(due);
                        slot = (slot + 1) % RING_SLOTS;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Beat checker
    always @(posedge clk)
    begin : check_beats
        take_beat_t got;
        take_beat_t want;
        if (rst_n && strobe)
        begin
            got = '{rec_valid,
                    '{rec_stamp_ms, rec_severity, rec_tag, rec_code, rec_arg},
                    last, pending_count, dropped_total};
            if (take_beats_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected beat: v=%0d stamp=%h arg=%0d last=%0d pend=%0d drop=%0d",
                             got.valid, got.rec.stamp, got.rec.arg, got.last,
                             got.pending, got.dropped);
            end
            else
            begin
                want = take_beats_due.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("beat mismatch at %0t", $realtime);
                        $display("  exp: v=%0d stamp=%h sev=%h tag=%h code=%h arg=%0d last=%0d pend=%0d drop=%0d",
                                 want.valid, want.rec.stamp, want.rec.sev, want.rec.tag,
                                 want.rec.code, want.rec.arg, want.last, want.pending,
                                 want.dropped);
                        $display("  got: v=%0d stamp=%h sev=%h tag=%h code=%h arg=%0d last=%0d pend=%0d drop=%0d",
                                 got.valid, got.rec.stamp, got.rec.sev, got.rec.tag,
                                 got.rec.code, got.rec.arg, got.last, got.pending,
                                 got.dropped);
                    end
                end
            end
        end
    end

    function automatic cmd_beat_t random_beat();
        cmd_beat_t beat;
        beat.command    = 2'($urandom_range(0, 3));
        beat.stamp_ms   = $urandom;
        beat.severity   = 8'($urandom_range(0, 255));
        beat.source_tag = 8'($urandom_range(0, 255));
        beat.event_code = 8'($urandom_range(0, 255));
        beat.event_arg  = $urandom;
        beat.take_limit = 8'($urandom_range(0, 255));
        return beat;
    endfunction

    // Drive one command beat; called and returns at a falling edge with start high
    task automatic send_beat(input cmd_beat_t beat);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        command    <= beat.command;
        stamp_ms   <= beat.stamp_ms;
        severity   <= beat.severity;
        source_tag <= beat.source_tag;
        event_code <= beat.event_code;
        event_arg  <= beat.event_arg;
        take_limit <= beat.take_limit;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        apply_ring_command(beat);
        @(negedge clk);
    endtask

    task automatic write_record(input logic [31:0] stamp, input logic [7:0] sev,
                                input logic [7:0] tag, input logic [7:0] code,
                                input logic signed [31:0] arg);
        cmd_beat_t beat;
        beat = random_beat();
        beat.command    = ore_pkg::CMD_WRITE;
        beat.stamp_ms   = stamp;
        beat.severity   = sev;
        beat.source_tag = tag;
        beat.event_code = code;
        beat.event_arg  = arg;
        send_beat(beat);
    endtask

    task automatic write_random();
        write_record($urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), $urandom);
    endtask

    task automatic take_records(input logic [7:0] limit);
        cmd_beat_t beat;
        beat = random_beat();
        beat.command    = ore_pkg::CMD_TAKE;
        beat.take_limit = limit;
        send_beat(beat);
    endtask

    task automatic send_plain(input logic [1:0] cmd);
        cmd_beat_t beat;
        beat = random_beat();
        beat.command = cmd;
        send_beat(beat);
    endtask

    // Hold the sender off until every predicted beat has come out
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (take_beats_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Takes on an empty ring, with zero and nonzero limits
    task automatic test_empty_take();
        take_records(8'd5);
        take_records(8'd0);
        take_records(8'd255);
    endtask

    // Field extremes, zero limit with records pending, limit above pending
    task automatic test_field_extremes();
        write_record(32'h0000_0000, 8'h00, 8'h00, 8'h00, 32'sh0000_0000);
        write_record(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, -32'sd1);
        write_record(32'hA5A5_5A5A, 8'h80, 8'h01, 8'h7F, 32'sh8000_0000);
        write_record(32'h5A5A_A5A5, 8'h01, 8'h80, 8'hFE, 32'sh7FFF_FFFF);
        take_records(8'd0);
        take_records(8'd1);
        take_records(8'd255);
        take_records(8'd1);
    endtask

    // Command 3 must leave the ring alone
    task automatic test_unused_command();
        send_plain(CMD_UNUSED);
        take_records(8'd4);
        write_random();
        send_plain(CMD_UNUSED);
        take_records(8'd2);
    endtask

    // Clear drops pending records
    task automatic test_clear();
        write_random();
        write_random();
        write_random();
        send_plain(ore_pkg::CMD_CLEAR);
        take_records(8'd3);
        write_random();
        take_records(8'd3);
    endtask

    // Fill, keep overwriting so the dropped counter runs up, then drain
    task automatic test_overflow_wrap();
        idling_on = 1'b0;
        send_plain(ore_pkg::CMD_CLEAR);
        repeat (RING_SLOTS) write_random();
        take_records(8'd0);
        repeat (40) write_random();
        take_records(8'd255);
        write_random();
        write_random();
        take_records(8'd2);
        send_plain(ore_pkg::CMD_CLEAR);
        take_records(8'd1);
        idling_on = 1'b1;
    endtask

    // Mixed traffic; write-heavy stretches push the ring into overflow
    task automatic test_random_traffic();
        cmd_beat_t   beat;
        int unsigned pick;
        bit          heavy;
        for (int n = 0; n < 300; n++)
        begin
            idling_on = (n < 225);
            if (n == 110)
                wait_drained();
            heavy = ((n / 50) % 2 == 1);
            pick  = $urandom_range(0, 99);
            beat  = random_beat();
            if (pick < (heavy ? 85 : 60))
                beat.command = ore_pkg::CMD_WRITE;
            else if (pick < 91)
            begin
                beat.command = ore_pkg::CMD_TAKE;
                case ($urandom_range(0, 9))
                    0: beat.take_limit = 8'd0;
                    1: beat.take_limit = heavy ? 8'($urandom_range(1, 4))
                                               : 8'($urandom_range(0, 255));
                    2: beat.take_limit = heavy ? 8'($urandom_range(1, 4))
                                               : 8'($urandom_range(30, 40));
                    default: beat.take_limit = 8'($urandom_range(1, 4));
                endcase
            end
            else if (pick < 96)
                beat.command = ore_pkg::CMD_CLEAR;
            else
                beat.command = CMD_UNUSED;
            send_beat(beat);
        end
    endtask

    initial
    begin
        head_slot      = 0;
        pending_recs   = 0;
        dropped_recs   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        idling_on      = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_take();
        test_field_extremes();
        test_unused_command();
        test_clear();
        test_overflow_wrap();
        test_random_traffic();

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && take_beats_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/ore_pkg.sv
src/ore_ctrl.sv
src/ore_datapath.sv
src/overwriting_event_record_ring.sv
bench/tb_overwriting_event_record_ring.sv
